/* sv/spsb_pkg.sv */
// Shared types, codes, constants and helper functions of the sprite blitter.
package spsb_pkg;

    // Item kinds carried on the input tuser
    localparam logic [1:0] OP_PAL_LOAD    = 2'd0;
    localparam logic [1:0] OP_BLIT_START  = 2'd1;
    localparam logic [1:0] OP_PIXEL       = 2'd2;

    // Register indexes
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_PITCH_WORDS   = 3'd2;
    localparam logic [2:0] CFG_SPR_WIDTH     = 3'd3;
    localparam logic [2:0] CFG_SPR_HEIGHT    = 3'd4;
    localparam logic [2:0] CFG_SCALE         = 3'd5;
    localparam logic [2:0] CFG_TRANSP_EN     = 3'd6;
    localparam logic [2:0] CFG_KEY_COLOR     = 3'd7;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int COLOR_W     = 32;
    localparam int OUT_ADDR_W  = 23;
    localparam int POS_W       = 13;
    localparam int DIM_W       = 9;
    localparam int SCALE_W     = 4;
    localparam int SCNT_W      = 3;
    localparam int DIV_STEPS   = 13;
    localparam int QUEUE_DEPTH = 4;

    localparam int DEF_PALETTE_ENTRIES = 256;
    localparam int DEF_MAX_SCALE       = 8;
    localparam int DEF_FB_ADDR_BITS    = 23;

    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd320;
    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd240;
    localparam logic [12:0] RST_PITCH_WORDS   = 13'd320;
    localparam logic [8:0]  RST_SPR_WIDTH     = 9'd16;
    localparam logic [8:0]  RST_SPR_HEIGHT    = 9'd16;
    localparam logic [3:0]  RST_SCALE         = 4'd1;

    typedef struct packed {
        logic [11:0]        screen_width;
        logic [11:0]        screen_height;
        logic [12:0]        pitch_words;
        logic [DIM_W-1:0]   spr_width;
        logic [DIM_W-1:0]   spr_height;
        logic [SCALE_W-1:0] scale;
        logic               transparent_enable;
        logic [COLOR_W-1:0] key_color;
    } t_cfg;

    typedef struct packed {
        logic idle;
        logic blit_on;
    } t_fstat;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        eff_dim = (d == '0) ? DIM_W'(1) : d;
    endfunction

    function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s,
                                                      input logic [SCALE_W-1:0] max_s);
        if (s == '0) begin
            eff_scale = SCALE_W'(1);
        end else if (s > max_s) begin
            eff_scale = max_s;
        end else begin
            eff_scale = s;
        end
    endfunction

endpackage

/* sv/spsb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module spsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/spsb_queue.sv */
// Small first-in first-out job queue between the front and back parts.
module spsb_queue #(
    parameter int WIDTH = 55,
    parameter int DEPTH = spsb_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* sv/spsb_front.sv */
// Front part: accepts items, keeps the palette, works out clips and classifies pixels.
module spsb_front #(
    parameter int PALETTE_ENTRIES = spsb_pkg::DEF_PALETTE_ENTRIES,
    parameter int MAX_SCALE       = spsb_pkg::DEF_MAX_SCALE,
    parameter int FB_ADDR_BITS    = spsb_pkg::DEF_FB_ADDR_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  spsb_pkg::t_cfg                         i_cfg,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [1:0]                             i_op,
    input  logic signed [spsb_pkg::POS_W-1:0]      i_pos_x,
    input  logic signed [spsb_pkg::POS_W-1:0]      i_pos_y,
    input  logic [7:0]                             i_slot,
    input  logic [spsb_pkg::COLOR_W-1:0]           i_color,
    input  logic [7:0]                             i_index,
    output logic                                   o_push,
    output logic [FB_ADDR_BITS+spsb_pkg::COLOR_W-1:0] o_push_data,
    input  logic                                   i_full,
    output spsb_pkg::t_fstat                       o_stat
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam int FB = FB_ADDR_BITS;
    localparam int DW = spsb_pkg::DIM_W;
    localparam int CW = spsb_pkg::COLOR_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CLIP = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0]              r_state;
    logic [spsb_pkg::POS_W-1:0] r_origin_x;
    logic [spsb_pkg::POS_W-1:0] r_origin_y;
    logic [DW-1:0]           r_clip_l;
    logic [DW-1:0]           r_clip_r;
    logic [DW-1:0]           r_clip_t;
    logic [DW-1:0]           r_clip_b;
    logic [DW-1:0]           r_src_col;
    logic [DW-1:0]           r_src_row;
    logic                    r_blit_off;
    logic [3:0]              r_div_cnt;
    logic [12:0]             r_dq  [4];
    logic [3:0]              r_rem [4];
    logic                    r_vis;
    logic                    r_idx_ok;
    logic signed [13:0]      r_bx;
    logic signed [13:0]      r_by;
    logic [FB-1:0]           r_prod;
    logic                    r_draw;
    logic [CW-1:0]           r_color;

    logic [spsb_pkg::SCALE_W-1:0] s;
    logic [DW-1:0]           sw;
    logic [DW-1:0]           sh;
    logic                    accept;
    logic signed [14:0]      px15;
    logic signed [14:0]      py15;
    logic [12:0]             span_x;
    logic [12:0]             span_y;
    logic signed [14:0]      over_x;
    logic signed [14:0]      over_y;
    logic                    off_screen;
    logic [12:0]             dvd [4];
    logic [4:0]              div_t  [4];
    logic                    div_ge [4];
    logic [13:0]             quo [4];
    logic [DW-1:0]           clip_n [4];
    logic [DW-1:0]           col;
    logic [DW-1:0]           row;
    logic                    col_end;
    logic                    row_end;
    logic                    vis;
    logic [12:0]             cs;
    logic [12:0]             rs;
    logic signed [13:0]      bx;
    logic signed [13:0]      by;
    logic signed [26:0]      prod27;
    logic                    slot_ok;
    logic                    pal_we;
    logic                    pal_re;
    logic [CW-1:0]           pal_rdata;
    logic [CW-1:0]           px_color;

    assign s  = spsb_pkg::eff_scale(i_cfg.scale, spsb_pkg::SCALE_W'(MAX_SCALE));
    assign sw = spsb_pkg::eff_dim(i_cfg.spr_width);
    assign sh = spsb_pkg::eff_dim(i_cfg.spr_height);

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    // Blit start: screen overlap and leading/trailing overhang per axis
    assign px15   = 15'(i_pos_x);
    assign py15   = 15'(i_pos_y);
    assign span_x = {4'b0, sw} * {9'b0, s};
    assign span_y = {4'b0, sh} * {9'b0, s};
    assign over_x = px15 + $signed({2'b0, span_x}) - $signed({3'b0, i_cfg.screen_width});
    assign over_y = py15 + $signed({2'b0, span_y}) - $signed({3'b0, i_cfg.screen_height});
    assign off_screen = (px15 >= $signed({3'b0, i_cfg.screen_width})) ||
                        (py15 >= $signed({3'b0, i_cfg.screen_height}));

    assign dvd[0] = (px15 < 0) ? 13'(-px15) : '0;
    assign dvd[1] = (over_x > 0) ? over_x[12:0] : '0;
    assign dvd[2] = (py15 < 0) ? 13'(-py15) : '0;
    assign dvd[3] = (over_y > 0) ? over_y[12:0] : '0;

    // Four restoring dividers by the scale, one quotient bit per cycle
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            div_t[i]  = {r_rem[i], r_dq[i][12]};
            div_ge[i] = (div_t[i] >= {1'b0, s});
            quo[i]    = {1'b0, r_dq[i]} + {13'b0, (r_rem[i] != '0)};
            if (quo[i] > {5'b0, ((i < 2) ? sw : sh)}) begin
                clip_n[i] = (i < 2) ? sw : sh;
            end else begin
                clip_n[i] = quo[i][DW-1:0];
            end
        end
    end

    // Pixel position and visibility
    assign col     = (r_src_col >= sw) ? '0 : r_src_col;
    assign row     = (r_src_row >= sh) ? '0 : r_src_row;
    assign col_end = ({1'b0, col} + 10'd1) >= {1'b0, sw};
    assign row_end = ({1'b0, row} + 10'd1) >= {1'b0, sh};
    assign vis     = (col >= r_clip_l) && (row >= r_clip_t) &&
                     (({1'b0, col} + {1'b0, r_clip_r}) < {1'b0, sw}) &&
                     (({1'b0, row} + {1'b0, r_clip_b}) < {1'b0, sh});
    assign cs = {4'b0, col} * {9'b0, s};
    assign rs = {4'b0, row} * {9'b0, s};
    assign bx = $signed({r_origin_x[12], r_origin_x}) + $signed({1'b0, cs});
    assign by = $signed({r_origin_y[12], r_origin_y}) + $signed({1'b0, rs});

    assign prod27 = 27'(r_by) * $signed(27'({1'b0, i_cfg.pitch_words}));

    // Palette
    assign slot_ok = ({1'b0, i_slot} < 9'(PALETTE_ENTRIES));
    assign pal_we  = accept && (i_op == spsb_pkg::OP_PAL_LOAD) && slot_ok;
    assign pal_re  = accept && (i_op == spsb_pkg::OP_PIXEL);

    spsb_ram #(
        .WIDTH (CW),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (i_slot[AW-1:0]),
        .i_wdata (i_color),
        .i_re    (pal_re),
        .i_raddr (i_index[AW-1:0]),
        .o_rdata (pal_rdata)
    );

    assign px_color = r_idx_ok ? pal_rdata : '0;

    assign o_push      = (r_state == ST_PUSH) && r_draw && !i_full;
    assign o_push_data = {r_color, r_prod + FB'(r_bx)};

    assign o_stat.idle    = (r_state == ST_IDLE);
    assign o_stat.blit_on = !r_blit_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_clip_l   <= '0;
            r_clip_r   <= '0;
            r_clip_t   <= '0;
            r_clip_b   <= '0;
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_blit_off <= 1'b1;
            r_div_cnt  <= '0;
            r_draw     <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept && (i_op == spsb_pkg::OP_BLIT_START)) begin
                        r_origin_x <= i_pos_x;
                        r_origin_y <= i_pos_y;
                        r_src_col  <= '0;
                        r_src_row  <= '0;
                        r_clip_l   <= '0;
                        r_clip_r   <= '0;
                        r_clip_t   <= '0;
                        r_clip_b   <= '0;
                        r_blit_off <= off_screen;
                        r_div_cnt  <= '0;
                        if (!off_screen) begin
                            r_state <= ST_DIV;
                        end
                    end else if (accept && (i_op == spsb_pkg::OP_PIXEL) && !r_blit_off) begin
                        if (col_end) begin
                            r_src_col <= '0;
                            if (row_end) begin
                                r_src_row  <= '0;
                                r_blit_off <= 1'b1;
                            end else begin
                                r_src_row <= row + DW'(1);
                            end
                        end else begin
                            r_src_col <= col + DW'(1);
                            r_src_row <= row;
                        end
                        r_state <= ST_MUL;
                    end
                end
                ST_DIV: begin
                    r_div_cnt <= r_div_cnt + 4'd1;
                    if (r_div_cnt == 4'(spsb_pkg::DIV_STEPS - 1)) begin
                        r_state <= ST_CLIP;
                    end
                end
                ST_CLIP: begin
                    r_clip_l <= clip_n[0];
                    r_clip_r <= clip_n[1];
                    r_clip_t <= clip_n[2];
                    r_clip_b <= clip_n[3];
                    r_state  <= ST_IDLE;
                end
                ST_MUL: begin
                    r_draw  <= r_vis && !(i_cfg.transparent_enable &&
                                          (px_color == i_cfg.key_color));
                    r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!r_draw || !i_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept && (i_op == spsb_pkg::OP_BLIT_START)) begin
            for (int i = 0; i < 4; i++) begin
                r_dq[i]  <= dvd[i];
                r_rem[i] <= '0;
            end
        end else if (r_state == ST_DIV) begin
            for (int i = 0; i < 4; i++) begin
                r_dq[i]  <= {r_dq[i][11:0], div_ge[i]};
                r_rem[i] <= div_ge[i] ? 4'(div_t[i] - {1'b0, s}) : div_t[i][3:0];
            end
        end
        if (accept && (i_op == spsb_pkg::OP_PIXEL)) begin
            r_vis    <= vis;
            r_bx     <= bx;
            r_by     <= by;
            r_idx_ok <= ({1'b0, i_index} < 9'(PALETTE_ENTRIES));
        end
        if (r_state == ST_MUL) begin
            r_prod  <= FB'(prod27);
            r_color <= px_color;
        end
    end

endmodule

/* sv/spsb_back.sv */
// Back part: turns each queued pixel into scale-by-scale frame buffer writes.
module spsb_back #(
    parameter int MAX_SCALE    = spsb_pkg::DEF_MAX_SCALE,
    parameter int FB_ADDR_BITS = spsb_pkg::DEF_FB_ADDR_BITS
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  spsb_pkg::t_cfg                            i_cfg,
    input  logic                                      i_q_valid,
    output logic                                      o_q_pop,
    input  logic [FB_ADDR_BITS+spsb_pkg::COLOR_W-1:0] i_q_data,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [spsb_pkg::OUT_ADDR_W-1:0]           o_addr,
    output logic [spsb_pkg::COLOR_W-1:0]              o_color,
    output logic                                      o_last
);

    localparam int FB = FB_ADDR_BITS;
    localparam int CW = spsb_pkg::COLOR_W;
    localparam int NW = spsb_pkg::SCNT_W;

    logic                  r_busy;
    logic [FB-1:0]         r_cur;
    logic [FB-1:0]         r_row;
    logic [CW-1:0]         r_color;
    logic [NW-1:0]         r_sx;
    logic [NW-1:0]         r_sy;
    logic                  r_out_valid;
    logic [FB-1:0]         r_out_addr;
    logic [CW-1:0]         r_out_color;
    logic                  r_out_last;

    logic [spsb_pkg::SCALE_W-1:0] s;
    logic [NW-1:0]         s_m1;
    logic [FB-1:0]         pitch;
    logic                  out_free;
    logic                  emit;
    logic                  at_last;
    logic                  take;

    assign s        = spsb_pkg::eff_scale(i_cfg.scale, spsb_pkg::SCALE_W'(MAX_SCALE));
    assign s_m1     = NW'(s - spsb_pkg::SCALE_W'(1));
    assign pitch    = FB'(i_cfg.pitch_words);
    assign out_free = !r_out_valid || i_ready;
    assign emit     = r_busy && out_free;
    assign at_last  = (r_sx == s_m1) && (r_sy == s_m1);
    assign take     = i_q_valid && (!r_busy || (emit && at_last));
    assign o_q_pop  = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
            end else if (emit && at_last) begin
                r_busy <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur   <= i_q_data[FB-1:0];
            r_row   <= i_q_data[FB-1:0];
            r_color <= i_q_data[FB+CW-1:FB];
            r_sx    <= '0;
            r_sy    <= '0;
        end else if (emit && !at_last) begin
            if (r_sx == s_m1) begin
                r_sx  <= '0;
                r_sy  <= r_sy + NW'(1);
                r_row <= r_row + pitch;
                r_cur <= r_row + pitch;
            end else begin
                r_sx  <= r_sx + NW'(1);
                r_cur <= r_cur + FB'(1);
            end
        end
        if (emit) begin
            r_out_addr  <= r_cur;
            r_out_color <= r_color;
            r_out_last  <= at_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_addr  = spsb_pkg::OUT_ADDR_W'(r_out_addr);
    assign o_color = r_out_color;
    assign o_last  = r_out_last;

endmodule

/* sv/scaled_palette_sprite_blitter_unit.sv */
// Top level of the scaled palette sprite blitter: registers, front, queue and back.
//
//  channel  direction  transfers
//  s_axis   in         tuser op, tdata pos_x/pos_y/palette_slot/palette_color/pixel_index
//  m_axis   out        tdata write_address/write_color, tlast last write of a pixel
//  cfg      in         i_cfg_we, i_cfg_index, i_cfg_data, one register per write
//
// Blit start: 13-step divide by the scale, then clip; skipped for an off-screen start.
// Sprite pixel: palette read, row multiply, queue push; for a drawn pixel the back makes
// scale*scale writes, one per cycle while m_axis is ready; large scales set the rate.
// Reset (i_rst_n low, synchronous) clears control state; palette contents are undefined.
// A 4-entry queue lets the front keep taking pixels while m_axis is stalled.
module scaled_palette_sprite_blitter_unit #(
    parameter int PALETTE_ENTRIES = spsb_pkg::DEF_PALETTE_ENTRIES,
    parameter int MAX_SCALE       = spsb_pkg::DEF_MAX_SCALE,
    parameter int FB_ADDR_BITS    = spsb_pkg::DEF_FB_ADDR_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [12:0] pos_x, [25:13] pos_y, [33:26] palette_slot, [65:34] palette_color,
    // [73:66] pixel_index, [79:74] zero
    input  logic [79:0]                        s_axis_tdata,
    // [1:0] op
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [22:0] write_address, [54:23] write_color, [55] zero
    output logic [55:0]                        m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_we,
    input  logic [spsb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [spsb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int QW = FB_ADDR_BITS + spsb_pkg::COLOR_W;

    spsb_pkg::t_cfg   r_cfg;
    spsb_pkg::t_fstat fstat;
    logic             q_push;
    logic [QW-1:0]    q_wdata;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic [QW-1:0]    q_rdata;
    logic [spsb_pkg::OUT_ADDR_W-1:0] out_addr;
    logic [spsb_pkg::COLOR_W-1:0]    out_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width       <= spsb_pkg::RST_SCREEN_WIDTH;
            r_cfg.screen_height      <= spsb_pkg::RST_SCREEN_HEIGHT;
            r_cfg.pitch_words        <= spsb_pkg::RST_PITCH_WORDS;
            r_cfg.spr_width          <= spsb_pkg::RST_SPR_WIDTH;
            r_cfg.spr_height         <= spsb_pkg::RST_SPR_HEIGHT;
            r_cfg.scale              <= spsb_pkg::RST_SCALE;
            r_cfg.transparent_enable <= 1'b0;
            r_cfg.key_color          <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spsb_pkg::CFG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data[11:0];
                spsb_pkg::CFG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data[11:0];
                spsb_pkg::CFG_PITCH_WORDS:   r_cfg.pitch_words   <= i_cfg_data[12:0];
                spsb_pkg::CFG_SPR_WIDTH:     r_cfg.spr_width     <= i_cfg_data[8:0];
                spsb_pkg::CFG_SPR_HEIGHT:    r_cfg.spr_height    <= i_cfg_data[8:0];
                spsb_pkg::CFG_SCALE:         r_cfg.scale         <= i_cfg_data[3:0];
                spsb_pkg::CFG_TRANSP_EN:     r_cfg.transparent_enable <= i_cfg_data[0];
                spsb_pkg::CFG_KEY_COLOR:     r_cfg.key_color     <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    spsb_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .MAX_SCALE       (MAX_SCALE),
        .FB_ADDR_BITS    (FB_ADDR_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_pos_x     ($signed(s_axis_tdata[12:0])),
        .i_pos_y     ($signed(s_axis_tdata[25:13])),
        .i_slot      (s_axis_tdata[33:26]),
        .i_color     (s_axis_tdata[65:34]),
        .i_index     (s_axis_tdata[73:66]),
        .o_push      (q_push),
        .o_push_data (q_wdata),
        .i_full      (q_full),
        .o_stat      (fstat)
    );

    spsb_queue #(
        .WIDTH (QW),
        .DEPTH (spsb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_rdata)
    );

    spsb_back #(
        .MAX_SCALE    (MAX_SCALE),
        .FB_ADDR_BITS (FB_ADDR_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_data  (q_rdata),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_addr    (out_addr),
        .o_color   (out_color),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_color, out_addr};

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == spsb_pkg::OP_PIXEL) &&
         fstat.blit_on) |=> !s_axis_tready)
        else $error("front ready right after taking a drawn pixel");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fstat.idle == s_axis_tready)
        else $error("front ready does not match its idle state");

endmodule
